### hw/rtl/rtlk_pkg.sv
`timescale 1ns / 1ps
package rtlk_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int INTF_COUNT      = 16;
  localparam int INTF_W          = 4;
  localparam logic [INTF_W-1:0] INTF_LAST = INTF_W'(INTF_COUNT - 1);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic [1:0] ST_ROUTED   = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE = 2'd1;
  localparam logic [1:0] ST_ADDED    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       addr;
    logic [31:0]       mask;
    logic [31:0]       gateway;
    logic [INTF_W-1:0] intf_id;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       next_hop;
    logic [INTF_W-1:0] out_intf;
  } rsp_t;

  // one stored route, one RAM word
  typedef struct packed {
    logic [31:0]       dest;
    logic [31:0]       mask;
    logic [31:0]       gw;
    logic [INTF_W-1:0] port;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

endpackage

### hw/rtl/rtlk_ram.sv
`timescale 1ns / 1ps
module rtlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rtlk_ctrl.sv
`timescale 1ns / 1ps
module rtlk_ctrl #(
  parameter int TABLE_DEPTH = rtlk_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  rtlk_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output rtlk_pkg::rsp_t                 rsp,
  output logic                           wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  output logic [rtlk_pkg::ROUTE_W-1:0]   wr_data,
  output logic                           rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [rtlk_pkg::ROUTE_W-1:0]   rd_data
);
  import rtlk_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_INS0 = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  function automatic route_t mk_route(req_t r);
    route_t e;
    e.dest = r.addr;
    e.mask = r.mask;
    e.gw   = r.gateway;
    e.port = (32'(r.intf_id) >= INTF_COUNT) ? INTF_LAST : r.intf_id;
    return e;
  endfunction

  function automatic rsp_t mk_rsp(logic [1:0] s);
    rsp_t o;
    o.status   = s;
    o.next_hop = '0;
    o.out_intf = '0;
    return o;
  endfunction

  logic [2:0]       st, st_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  route_t           cur, cur_next;   // item held for the scan
  rsp_t             res, res_next;
  route_t           ent;
  logic             accept, load;
  logic [CNT_W-1:0] cnt_m1, idx_p1, idx_m1, idx_m2;

  assign ent    = route_t'(rd_data);
  assign cnt_m1 = count - CNT_W'(1);
  assign idx_p1 = idx + CNT_W'(1);
  assign idx_m1 = idx - CNT_W'(1);
  assign idx_m2 = idx - CNT_W'(2);

  assign req_ready = (st == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign load      = (st == S_RESP) && (!rsp_valid || rsp_ready);

  always_comb begin
    st_next    = st;
    count_next = count;
    idx_next   = idx;
    cur_next   = cur;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = idx[IDX_W-1:0];
    wr_data    = cur;
    rd_en      = 1'b0;
    rd_addr    = idx_p1[IDX_W-1:0];
    unique case (st)
      S_IDLE: begin
        if (accept) begin
          cur_next = mk_route(req);
          if (req.cmd == CMD_LOOKUP) begin
            if (count == '0) begin
              res_next = mk_rsp(ST_NO_ROUTE);
              st_next  = S_RESP;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = '0;
              idx_next = '0;
              st_next  = S_LOOK;
            end
          end else if (count == CNT_FULL) begin
            res_next = mk_rsp(ST_FULL);
            st_next  = S_RESP;
          end else if (count == '0) begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = mk_route(req);
            count_next = count + CNT_W'(1);
            res_next   = mk_rsp(ST_ADDED);
            st_next    = S_RESP;
          end else begin
            // walk down from the last entry, shifting smaller masks up
            rd_en    = 1'b1;
            rd_addr  = cnt_m1[IDX_W-1:0];
            idx_next = count;
            st_next  = S_INS;
          end
        end
      end
      S_LOOK: begin
        if ((cur.dest & ent.mask) == ent.dest) begin
          res_next.status   = ST_ROUTED;
          res_next.next_hop = (ent.gw != '0) ? ent.gw : cur.dest;
          res_next.out_intf = ent.port;
          st_next           = S_RESP;
        end else if (idx_p1 == count) begin
          res_next = mk_rsp(ST_NO_ROUTE);
          st_next  = S_RESP;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_p1[IDX_W-1:0];
          idx_next = idx_p1;
        end
      end
      S_INS: begin
        // ent is entry idx-1
        wr_en = 1'b1;
        if (ent.mask >= cur.mask) begin
          wr_data    = cur;
          count_next = count + CNT_W'(1);
          res_next   = mk_rsp(ST_ADDED);
          st_next    = S_RESP;
        end else begin
          wr_data = ent;
          if (idx == CNT_W'(1)) begin
            st_next = S_INS0;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx_m2[IDX_W-1:0];
            idx_next = idx_m1;
          end
        end
      end
      S_INS0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = cur;
        count_next = count + CNT_W'(1);
        res_next   = mk_rsp(ST_ADDED);
        st_next    = S_RESP;
      end
      S_RESP: begin
        if (load) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      st    <= st_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    cur <= cur_next;
    res <= res_next;
    if (load) begin
      rsp <= res;
    end
  end

endmodule

### hw/rtl/ipv4_route_table_lookup_core.sv
`timescale 1ns / 1ps
// Route table, one RAM word per route, scanned one entry per cycle.
// Lookup: entries are examined from the first upward until a match or the end, 0 to N entries.
// Add: entries with a smaller mask are shifted up by one (at most N - 1); no shift if empty or full.
// One item in flight; the next word is accepted the cycle after the result is loaded.
// Sync reset empties the table (count only) and clears rsp_valid; RAM and the output word are not cleared.
module ipv4_route_table_lookup_core #(
  parameter int TABLE_DEPTH = rtlk_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rtlk_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rtlk_pkg::rsp_t rsp
);
  import rtlk_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [ROUTE_W-1:0] wr_data, rd_data;

  rtlk_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  rtlk_ram #(
    .WIDTH(ROUTE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

`ifndef ASSERT_OFF
  // an accepted word always leaves the engine busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("engine ready straight after accept");

  // the shift never reads the slot it is writing
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write to same entry");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_NO_ROUTE || rsp.status == ST_ADDED ||
                  rsp.status == ST_FULL)
    |-> rsp.next_hop == '0 && rsp.out_intf == '0)
    else $error("non-routed result carries hop or interface");

  // RAM only touched while an item is being worked on
  a_ram_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready && !req_valid |-> !wr_en && !rd_en)
    else $error("RAM access while idle");
`endif

endmodule
